// File: rtl/core/rotated_quad_vertex_generator_unit_defines.svh
// Assertion macros used by rqvg_checker, the verification file of the quad vertex generator.
// Depends on nothing; include once per file that asserts.
`ifndef ROTATED_QUAD_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define ROTATED_QUAD_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RQVG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqvg: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define RQVG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqvg: next-cycle check failed");

`endif

// File: rtl/core/rqvg_pkg.sv
// Shared types, widths, constants and corner helpers for the quad vertex generator.
// No dependencies; imported by rqvg_cordic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rqvg_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int SIZE_W  = 23;
  localparam int ANGLE_W = 16;
  localparam int COLOR_W = 8;
  localparam int LAYER_W = 16;
  localparam int TEX_W   = 12;

  // sine / cosine datapath, 1.0 = 32768
  localparam int TRIG_W = 18;
  localparam int Z_W    = 16;
  localparam logic signed [TRIG_W-1:0] CORDIC_START = 18'sd19898;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE     = 18'sd32768;
  localparam logic [ANGLE_W-1:0]       ANGLE_EIGHTH = 16'd8192;
  localparam logic signed [Z_W-1:0]    RESID_BIAS   = 16'sd8192;

  // CORDIC sequencing: a few micro-rotations per clock
  localparam int CORDIC_STEPS    = 14;
  localparam int STEPS_PER_CYCLE = 3;
  localparam int CORDIC_CYCLES   = (CORDIC_STEPS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
  localparam int CNT_W           = $clog2(CORDIC_CYCLES + 1);
  localparam int SIDX_W          = $clog2((CORDIC_CYCLES + 1) * STEPS_PER_CYCLE);
  localparam int STEP_IDX_W      = $clog2(CORDIC_STEPS);

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163,
    16'sd81,   16'sd41,   16'sd20,   16'sd10,   16'sd5,   16'sd3,   16'sd1
  };

  // quadrant codes after the eighth-turn offset
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quadrant_t;

  // CORDIC unit status toward the top level
  typedef struct packed {
    logic active;  // holds a request, iterating or finished
    logic done;    // sine / cosine ready for handoff
  } cordic_status_t;

  // centre sum 2*pos + size in 2^-9 units
  localparam int CX_W = COORD_W + 2;

  // vertex accumulation: centre * 2^15 plus two products
  localparam int PROD_W = TRIG_W + SIZE_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int FRAC_DROP = 16;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);
  localparam logic signed [ACC_W-FRAC_DROP-1:0] Q_MAX = (ACC_W-FRAC_DROP)'(8388607);
  localparam logic signed [ACC_W-FRAC_DROP-1:0] Q_MIN = -(ACC_W-FRAC_DROP)'(8388608);

  // vertex sequencing: tl, tr, br, br, bl, tl
  localparam int NUM_VERTS = 6;
  localparam int VTX_W     = $clog2(NUM_VERTS);
  typedef logic [VTX_W-1:0] vtx_idx_t;
  localparam vtx_idx_t LAST_VERT = VTX_W'(NUM_VERTS - 1);

  // corner lies on the +x half (tr, br)
  function automatic logic corner_right(input vtx_idx_t k);
    logic r;
    unique case (k)
      3'd1, 3'd2, 3'd3: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // corner lies on the +y half (br, bl)
  function automatic logic corner_bottom(input vtx_idx_t k);
    logic b;
    unique case (k)
      3'd2, 3'd3, 3'd4: b = 1'b1;
      default:          b = 1'b0;
    endcase
    return b;
  endfunction

  // round half up to Q15.8 and clamp to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0]           rnd;
    logic signed [ACC_W-FRAC_DROP-1:0] q;
    logic signed [COORD_W-1:0]         res;
    rnd = acc + ROUND_BIAS;
    q   = rnd[ACC_W-1:FRAC_DROP];
    if (q > Q_MAX) begin
      res = Q_MAX[COORD_W-1:0];
    end else if (q < Q_MIN) begin
      res = Q_MIN[COORD_W-1:0];
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rotated_quad_vertex_generator_unit.sv
// Rotated quad vertex generator: one quad request in, six vertices out (tl tr br br bl tl).
// Block usage:
//   Request: pos_x/pos_y/width/height/angle, colour, layer, texture_index are taken
//   at a rising edge where start is high and busy is low.
//   Results: one vertex per cycle while vert_valid is high; last_vertex marks the
//   sixth. The receiver has no stall: each vertex is shown for exactly one cycle.
//   Path: a request passes the CORDIC iterations, the vertex stage registers and the
//   result register; after the first vertex the other five follow on consecutive cycles.
//   Quad rate is bounded by the single vertex output port, six vertices per quad. The
//   CORDIC unit (three micro-rotations per clock) overlaps with the output of
//   the previous quad, so the next request can be taken while vertices stream out.
//   busy stays high from acceptance until the sine/cosine hand off to the vertex stage.
//   Reset (rst, synchronous) drops any request in flight; nothing is output after it
//   until a new request is accepted.
// Depends on rqvg_pkg and rqvg_cordic.
`timescale 1ns / 1ps
`default_nettype none

module rotated_quad_vertex_generator_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [rqvg_pkg::COORD_W-1:0]   pos_x,
  input  wire logic signed [rqvg_pkg::COORD_W-1:0]   pos_y,
  input  wire logic [rqvg_pkg::SIZE_W-1:0]           width,
  input  wire logic [rqvg_pkg::SIZE_W-1:0]           height,
  input  wire logic [rqvg_pkg::ANGLE_W-1:0]          angle,
  input  wire logic [rqvg_pkg::COLOR_W-1:0]          red,
  input  wire logic [rqvg_pkg::COLOR_W-1:0]          green,
  input  wire logic [rqvg_pkg::COLOR_W-1:0]          blue,
  input  wire logic [rqvg_pkg::COLOR_W-1:0]          alpha,
  input  wire logic [rqvg_pkg::LAYER_W-1:0]          layer,
  input  wire logic [rqvg_pkg::TEX_W-1:0]            texture_index,
  output logic                                       vert_valid,
  output logic signed [rqvg_pkg::COORD_W-1:0]        vert_x,
  output logic signed [rqvg_pkg::COORD_W-1:0]        vert_y,
  output logic                                       tex_u,
  output logic                                       tex_v,
  output logic [rqvg_pkg::COLOR_W-1:0]               out_red,
  output logic [rqvg_pkg::COLOR_W-1:0]               out_green,
  output logic [rqvg_pkg::COLOR_W-1:0]               out_blue,
  output logic [rqvg_pkg::COLOR_W-1:0]               out_alpha,
  output logic [rqvg_pkg::LAYER_W-1:0]               out_layer,
  output logic [rqvg_pkg::TEX_W-1:0]                 out_texture,
  output logic                                       last_vertex
);
  import rqvg_pkg::*;

  logic                     accept;
  logic                     take;
  logic                     e_free;
  cordic_status_t           cst;
  logic signed [TRIG_W-1:0] cos_val, sin_val;

  // request held while the CORDIC runs
  logic signed [COORD_W-1:0] p_x, p_y;
  logic [SIZE_W-1:0]         p_w, p_h;
  logic [COLOR_W-1:0]        p_red, p_green, p_blue, p_alpha;
  logic [LAYER_W-1:0]        p_layer;
  logic [TEX_W-1:0]          p_tex;

  // vertex stage
  logic                      e_active;
  vtx_idx_t                  e_cnt;
  logic signed [ACC_W-1:0]   e_cx, e_cy;
  logic signed [PROD_W-1:0]  e_cw, e_sh, e_sw, e_ch;
  logic [COLOR_W-1:0]        e_red, e_green, e_blue, e_alpha;
  logic [LAYER_W-1:0]        e_layer;
  logic [TEX_W-1:0]          e_tex;

  logic signed [CX_W-1:0]    cx_sum, cy_sum;
  logic signed [PROD_W-1:0]  cw, sh, sw, ch;
  logic                      sx_pos, sy_pos;
  logic signed [ACC_W-1:0]   cw_a, sh_a, sw_a, ch_a, x_acc, y_acc;

  // handshake
  assign e_free = !e_active || (e_cnt == LAST_VERT);
  assign take   = cst.done && e_free;
  assign busy   = cst.active && !take;
  assign accept = start && !busy;

  rqvg_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .angle   (angle),
    .take    (take),
    .status  (cst),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      p_x     <= pos_x;
      p_y     <= pos_y;
      p_w     <= width;
      p_h     <= height;
      p_red   <= red;
      p_green <= green;
      p_blue  <= blue;
      p_alpha <= alpha;
      p_layer <= layer;
      p_tex   <= texture_index;
    end
  end

  // centre in 2^-9 units and the four rotation products
  assign cx_sum = $signed({p_x[COORD_W-1], p_x, 1'b0}) + $signed({3'b000, p_w});
  assign cy_sum = $signed({p_y[COORD_W-1], p_y, 1'b0}) + $signed({3'b000, p_h});
  assign cw = PROD_W'(cos_val) * PROD_W'($signed({1'b0, p_w}));
  assign sh = PROD_W'(sin_val) * PROD_W'($signed({1'b0, p_h}));
  assign sw = PROD_W'(sin_val) * PROD_W'($signed({1'b0, p_w}));
  assign ch = PROD_W'(cos_val) * PROD_W'($signed({1'b0, p_h}));

  always_ff @(posedge clk) begin
    if (take) begin
      e_cx    <= {{(ACC_W-CX_W-15){cx_sum[CX_W-1]}}, cx_sum, 15'b0};
      e_cy    <= {{(ACC_W-CX_W-15){cy_sum[CX_W-1]}}, cy_sum, 15'b0};
      e_cw    <= cw;
      e_sh    <= sh;
      e_sw    <= sw;
      e_ch    <= ch;
      e_red   <= p_red;
      e_green <= p_green;
      e_blue  <= p_blue;
      e_alpha <= p_alpha;
      e_layer <= p_layer;
      e_tex   <= p_tex;
    end
  end

  // vertex counter
  always_ff @(posedge clk) begin
    if (rst) begin
      e_active <= 1'b0;
      e_cnt    <= '0;
    end else if (take) begin
      e_active <= 1'b1;
      e_cnt    <= '0;
    end else if (e_active) begin
      if (e_cnt == LAST_VERT) begin
        e_active <= 1'b0;
      end else begin
        e_cnt <= e_cnt + VTX_W'(1);
      end
    end
  end

  // corner position: centre +- products by corner signs
  assign sx_pos = corner_right(e_cnt);
  assign sy_pos = corner_bottom(e_cnt);
  assign cw_a   = ACC_W'(e_cw);
  assign sh_a   = ACC_W'(e_sh);
  assign sw_a   = ACC_W'(e_sw);
  assign ch_a   = ACC_W'(e_ch);
  assign x_acc  = e_cx + (sx_pos ? cw_a : -cw_a) + (sy_pos ? -sh_a : sh_a);
  assign y_acc  = e_cy + (sx_pos ? sw_a : -sw_a) + (sy_pos ? ch_a : -ch_a);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_valid  <= 1'b0;
      last_vertex <= 1'b0;
    end else begin
      vert_valid  <= e_active;
      last_vertex <= e_active && (e_cnt == LAST_VERT);
    end
  end

  always_ff @(posedge clk) begin
    if (e_active) begin
      vert_x      <= sat_coord(x_acc);
      vert_y      <= sat_coord(y_acc);
      tex_u       <= sx_pos;
      tex_v       <= !sy_pos;
      out_red     <= e_red;
      out_green   <= e_green;
      out_blue    <= e_blue;
      out_alpha   <= e_alpha;
      out_layer   <= e_layer;
      out_texture <= e_tex;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rqvg_cordic.sv
// Iterative sine / cosine unit: quadrant fold plus 14 CORDIC micro-rotations, three per clock.
// Depends on rqvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqvg_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                load,
  input  wire logic [rqvg_pkg::ANGLE_W-1:0]        angle,
  input  wire logic                                take,
  output rqvg_pkg::cordic_status_t                 status,
  output logic signed [rqvg_pkg::TRIG_W-1:0]       cos_val,
  output logic signed [rqvg_pkg::TRIG_W-1:0]       sin_val
);
  import rqvg_pkg::*;

  logic                     active;
  logic [CNT_W-1:0]         cnt;
  logic signed [TRIG_W-1:0] x, y;
  logic signed [Z_W-1:0]    z;
  quadrant_t                quad;
  logic                     rzero;

  logic [ANGLE_W-1:0]       shifted;
  logic signed [Z_W-1:0]    resid;
  logic                     finished;

  logic signed [TRIG_W-1:0] x_next, y_next, xs, ys;
  logic signed [Z_W-1:0]    z_next, at;
  logic [SIDX_W-1:0]        sidx;
  logic signed [TRIG_W-1:0] c_raw, s_raw;

  // angle split: quadrant and residual in [-8192, 8191]
  assign shifted  = angle + ANGLE_EIGHTH;
  assign resid    = $signed({2'b00, shifted[ANGLE_W-3:0]}) - RESID_BIAS;
  assign finished = (cnt == CNT_W'(CORDIC_CYCLES));

  // micro-rotations for this clock
  always_comb begin
    x_next = x;
    y_next = y;
    z_next = z;
    xs     = '0;
    ys     = '0;
    at     = '0;
    sidx   = '0;
    for (int j = 0; j < STEPS_PER_CYCLE; j++) begin
      sidx = SIDX_W'(cnt) * SIDX_W'(STEPS_PER_CYCLE) + SIDX_W'(j);
      if (sidx < SIDX_W'(CORDIC_STEPS)) begin
        xs = x_next >>> sidx;
        ys = y_next >>> sidx;
        at = ATAN_TAB[sidx[STEP_IDX_W-1:0]];
        if (!z_next[Z_W-1]) begin
          x_next = x_next - ys;
          y_next = y_next + xs;
          z_next = z_next - at;
        end else begin
          x_next = x_next + ys;
          y_next = y_next - xs;
          z_next = z_next + at;
        end
      end
    end
  end

  // request and iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (take) begin
      active <= 1'b0;
    end else if (active && !finished) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x     <= CORDIC_START;
      y     <= '0;
      z     <= resid;
      quad  <= quadrant_t'(shifted[ANGLE_W-1:ANGLE_W-2]);
      rzero <= (resid == '0);
    end else if (active && !finished) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  // exact axis override, then quadrant fold
  assign c_raw = rzero ? TRIG_ONE : x;
  assign s_raw = rzero ? '0 : y;

  always_comb begin
    unique case (quad)
      QUAD_0:   begin cos_val = c_raw;  sin_val = s_raw;  end
      QUAD_90:  begin cos_val = -s_raw; sin_val = c_raw;  end
      QUAD_180: begin cos_val = -c_raw; sin_val = -s_raw; end
      QUAD_270: begin cos_val = s_raw;  sin_val = -c_raw; end
      default:  begin cos_val = c_raw;  sin_val = s_raw;  end
    endcase
  end

  assign status = '{active: active, done: active && finished};

endmodule

`default_nettype wire

// File: rtl/core/rqvg_checker.sv
// Port-level checks on request acceptance and vertex sequencing, bound to the top level.
// Depends on rotated_quad_vertex_generator_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_quad_vertex_generator_unit_defines.svh"

module rqvg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic vert_valid,
  input wire logic last_vertex,
  input wire logic tex_u,
  input wire logic tex_v
);

  // an accepted request occupies the block on the next cycle
  `RQVG_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  // last marker only on a valid vertex
  `RQVG_ASSERT_IMP(a_last_valid, clk, rst, last_vertex, vert_valid)
  // vertices of one quad come on consecutive cycles
  `RQVG_ASSERT_NXT(a_burst, clk, rst, vert_valid && !last_vertex, vert_valid)
  // a quad that follows an idle output cycle opens at the top-left corner
  `RQVG_ASSERT_IMP(a_first_tl, clk, rst, vert_valid && !$past(vert_valid), !tex_u && tex_v)
  // and closes there
  `RQVG_ASSERT_IMP(a_last_tl, clk, rst, last_vertex, !tex_u && tex_v)

endmodule

bind rotated_quad_vertex_generator_unit rqvg_checker u_rqvg_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .vert_valid  (vert_valid),
  .last_vertex (last_vertex),
  .tex_u       (tex_u),
  .tex_v       (tex_v)
);

`default_nettype wire

// File: bench/tb_rotated_quad_vertex_generator_unit.sv
// Self-checking bench for the rotated quad vertex generator: quad requests in, six vertices out.
// Holds a vertex predictor and scoreboard package plus the top-level bench module.
// Depends on rqvg_pkg and rotated_quad_vertex_generator_unit.
`timescale 1ns / 1ps

package quad_check_pkg;
  import rqvg_pkg::*;

  // one quad request as driven on the input ports
  typedef struct {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic [ANGLE_W-1:0]        angle;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        alpha;
    logic [LAYER_W-1:0]        layer;
    logic [TEX_W-1:0]          texture_index;
  } quad_req_t;

  // one vertex as seen on the output ports
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      u;
    logic                      v;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        alpha;
    logic [LAYER_W-1:0]        layer;
    logic [TEX_W-1:0]          texture;
    logic                      last;
  } vertex_t;

  // micro-rotation angles in 1/65536 turn
  localparam int ROT_STEPS = 14;
  localparam int ROT_ANGLES [ROT_STEPS] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
  };
  localparam longint GAIN_START  = 19898;
  localparam longint UNIT_SCALE  = 32768;
  localparam longint COORD_TOP   = 8388607;
  localparam longint COORD_FLOOR = -8388608;

  // corner walk tl, tr, br, br, bl, tl: half-extent signs and texture coords
  localparam int CORNER_SX [6] = '{-1, 1, 1, 1, -1, -1};
  localparam int CORNER_SY [6] = '{-1, -1, 1, 1, 1, -1};
  localparam bit CORNER_U [6]  = '{0, 1, 1, 1, 0, 0};
  localparam bit CORNER_V [6]  = '{1, 1, 0, 0, 0, 1};

  // cos / sin scaled by 2^15: quadrant fold plus shift-add rotation of the residual
  function automatic void rotation_terms(input logic [ANGLE_W-1:0] angle,
                                         output longint cos_t, output longint sin_t);
    logic [ANGLE_W-1:0] shifted;
    quadrant_t          quad;
    longint             resid, x, y, z, xs, ys, c, s;
    shifted = angle + 16'd8192;
    quad    = quadrant_t'(shifted[15:14]);
    resid   = longint'(shifted[13:0]) - 8192;
    if (resid == 0) begin
      c = UNIT_SCALE;
      s = 0;
    end else begin
      x = GAIN_START;
      y = 0;
      z = resid;
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ROT_ANGLES[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ROT_ANGLES[i];
        end
      end
      c = x;
      s = y;
    end
    case (quad)
      QUAD_0: begin
        cos_t = c;
        sin_t = s;
      end
      QUAD_90: begin
        cos_t = -s;
        sin_t = c;
      end
      QUAD_180: begin
        cos_t = -c;
        sin_t = -s;
      end
      default: begin
        cos_t = s;
        sin_t = -c;
      end
    endcase
  endfunction

  // 2^-24 accumulator to Q15.8: round half up, clamp to 24 bit signed
  function automatic logic signed [COORD_W-1:0] to_q15_8(input longint acc);
    longint q;
    q = (acc + 32768) >>> 16;
    if (q > COORD_TOP) q = COORD_TOP;
    if (q < COORD_FLOOR) q = COORD_FLOOR;
    return q[COORD_W-1:0];
  endfunction

  class vertex_scoreboard;
    vertex_t pending_verts[$];
    int      mismatches;
    int      vertices_seen;

    function new();
      mismatches    = 0;
      vertices_seen = 0;
    endfunction

    // accepted request: queue up its six expected vertices
    function void note_quad(quad_req_t q);
      longint  c, s, px, py, w, h, cx, cy, hx, hy;
      vertex_t vt;
      rotation_terms(q.angle, c, s);
      px = longint'(q.pos_x);
      py = longint'(q.pos_y);
      w  = longint'(q.width);
      h  = longint'(q.height);
      cx = (2 * px + w) * UNIT_SCALE;
      cy = (2 * py + h) * UNIT_SCALE;
      for (int k = 0; k < 6; k++) begin
        hx         = CORNER_SX[k] * w;
        hy         = CORNER_SY[k] * h;
        vt.x       = to_q15_8(cx + c * hx - s * hy);
        vt.y       = to_q15_8(cy + s * hx + c * hy);
        vt.u       = CORNER_U[k];
        vt.v       = CORNER_V[k];
        vt.red     = q.red;
        vt.green   = q.green;
        vt.blue    = q.blue;
        vt.alpha   = q.alpha;
        vt.layer   = q.layer;
        vt.texture = q.texture_index;
        vt.last    = (k == 5);
        pending_verts.insert(pending_verts.size(), vt);
      end
    endfunction

    function int outstanding();
      return pending_verts.size();
    endfunction

    // one line per mismatch
    task report(input string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    // compare an observed vertex against the oldest expectation
    task check_vertex(input vertex_t got);
      vertex_t want;
      string   bad;
      bad = "";
      vertices_seen++;
      if (pending_verts.size() == 0) begin
        report($sformatf("vertex %0d arrived with nothing expected", vertices_seen));
      end else begin
        want = pending_verts.pop_front();
        if (got.x !== want.x) bad = {bad, " x"};
        if (got.y !== want.y) bad = {bad, " y"};
        if (got.u !== want.u) bad = {bad, " u"};
        if (got.v !== want.v) bad = {bad, " v"};
        if (got.red !== want.red) bad = {bad, " red"};
        if (got.green !== want.green) bad = {bad, " green"};
        if (got.blue !== want.blue) bad = {bad, " blue"};
        if (got.alpha !== want.alpha) bad = {bad, " alpha"};
        if (got.layer !== want.layer) bad = {bad, " layer"};
        if (got.texture !== want.texture) bad = {bad, " texture"};
        if (got.last !== want.last) bad = {bad, " last"};
        if (bad != "") begin
          report($sformatf("vertex %0d bad:%s (x %0d/%0d y %0d/%0d uv %b%b/%b%b)",
                           vertices_seen, bad, got.x, want.x, got.y, want.y,
                           got.u, got.v, want.u, want.v));
        end
      end
    endtask
  endclass

endpackage

module tb_rotated_quad_vertex_generator_unit;
  import rqvg_pkg::*;
  import quad_check_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 150;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] pos_x = '0;
  logic signed [COORD_W-1:0] pos_y = '0;
  logic [SIZE_W-1:0]         width = '0;
  logic [SIZE_W-1:0]         height = '0;
  logic [ANGLE_W-1:0]        angle = '0;
  logic [COLOR_W-1:0]        red = '0;
  logic [COLOR_W-1:0]        green = '0;
  logic [COLOR_W-1:0]        blue = '0;
  logic [COLOR_W-1:0]        alpha = '0;
  logic [LAYER_W-1:0]        layer = '0;
  logic [TEX_W-1:0]          texture_index = '0;
  logic                      vert_valid;
  logic signed [COORD_W-1:0] vert_x;
  logic signed [COORD_W-1:0] vert_y;
  logic                      tex_u;
  logic                      tex_v;
  logic [COLOR_W-1:0]        out_red;
  logic [COLOR_W-1:0]        out_green;
  logic [COLOR_W-1:0]        out_blue;
  logic [COLOR_W-1:0]        out_alpha;
  logic [LAYER_W-1:0]        out_layer;
  logic [TEX_W-1:0]          out_texture;
  logic                      last_vertex;

  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  vertex_scoreboard board = new();

  always #5 clk = ~clk;

  rotated_quad_vertex_generator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .width         (width),
    .height        (height),
    .angle         (angle),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .layer         (layer),
    .texture_index (texture_index),
    .vert_valid    (vert_valid),
    .vert_x        (vert_x),
    .vert_y        (vert_y),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_layer     (out_layer),
    .out_texture   (out_texture),
    .last_vertex   (last_vertex)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // request acceptance and vertex checking, both on the same edge sample
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_quad('{pos_x: pos_x, pos_y: pos_y, width: width, height: height,
                          angle: angle, red: red, green: green, blue: blue,
                          alpha: alpha, layer: layer, texture_index: texture_index});
      end
      if (vert_valid) begin
        board.check_vertex('{x: vert_x, y: vert_y, u: tex_u, v: tex_v, red: out_red,
                             green: out_green, blue: out_blue, alpha: out_alpha,
                             layer: out_layer, texture: out_texture, last: last_vertex});
      end
    end
  end

  // present a request and hold it until the block takes it; start stays high
  task automatic send_quad(input quad_req_t q);
    start         <= 1'b1;
    pos_x         <= q.pos_x;
    pos_y         <= q.pos_y;
    width         <= q.width;
    height        <= q.height;
    angle         <= q.angle;
    red           <= q.red;
    green         <= q.green;
    blue          <= q.blue;
    alpha         <= q.alpha;
    layer         <= q.layer;
    texture_index <= q.texture_index;
    do @(posedge clk); while (busy);
  endtask

  // sender gap: start low while the given number of clock edges pass
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every expected vertex has come out
  task automatic drain();
    hold_off(1);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_directed(input int px, input int py, input int w, input int h,
                               input int ang, input fill_t fill);
    quad_req_t q;
    q.pos_x  = px[COORD_W-1:0];
    q.pos_y  = py[COORD_W-1:0];
    q.width  = w[SIZE_W-1:0];
    q.height = h[SIZE_W-1:0];
    q.angle  = ang[ANGLE_W-1:0];
    case (fill)
      FILL_ZERO: begin
        {q.red, q.green, q.blue, q.alpha, q.layer, q.texture_index} = '0;
      end
      FILL_ONES: begin
        {q.red, q.green, q.blue, q.alpha, q.layer, q.texture_index} = '1;
      end
      default: begin
        q.red           = 8'($urandom);
        q.green         = 8'($urandom);
        q.blue          = 8'($urandom);
        q.alpha         = 8'($urandom);
        q.layer         = 16'($urandom);
        q.texture_index = 12'($urandom);
      end
    endcase
    send_quad(q);
  endtask

  // mostly sprite-sized quads; some full range, axis angles and degenerate sizes
  function automatic quad_req_t random_quad();
    quad_req_t q;
    int        roll;
    roll            = $urandom_range(99);
    q.red           = 8'($urandom);
    q.green         = 8'($urandom);
    q.blue          = 8'($urandom);
    q.alpha         = 8'($urandom);
    q.layer         = 16'($urandom);
    q.texture_index = 12'($urandom);
    q.angle         = 16'($urandom);
    if (roll < 60) begin
      q.pos_x  = 24'(int'($urandom_range(0, 2097151)) - 1048576);
      q.pos_y  = 24'(int'($urandom_range(0, 2097151)) - 1048576);
      q.width  = 23'($urandom_range(0, 131071));
      q.height = 23'($urandom_range(0, 131071));
    end else if (roll < 80) begin
      q.pos_x  = 24'($urandom);
      q.pos_y  = 24'($urandom);
      q.width  = 23'($urandom);
      q.height = 23'($urandom);
    end else if (roll < 90) begin
      q.pos_x  = 24'(int'($urandom_range(0, 65535)) - 32768);
      q.pos_y  = 24'(int'($urandom_range(0, 65535)) - 32768);
      q.width  = 23'($urandom_range(0, 4095));
      q.height = 23'($urandom_range(0, 4095));
      q.angle  = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
    end else begin
      q.pos_x  = 24'($urandom);
      q.pos_y  = 24'($urandom);
      q.width  = 23'($urandom_range(0, 3));
      q.height = 23'($urandom_range(0, 3));
    end
    return q;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, axis angles, quadrant edges, saturation, rounding
    send_directed(0, 0, 0, 0, 0, FILL_ZERO);
    send_directed(8388607, 8388607, 8388607, 8388607, 0, FILL_ONES);
    send_directed(-8388608, -8388608, 0, 0, 0, FILL_ZERO);
    send_directed(-8388608, -8388608, 8388607, 8388607, 32768, FILL_ONES);
    send_directed(-8388608, 8388607, 8388607, 8388607, 8192, FILL_RANDOM);
    send_directed(8388607, -8388608, 8388607, 8388607, 40960, FILL_RANDOM);
    send_directed(8388607, 8388607, 8388607, 0, 65535, FILL_RANDOM);
    send_directed(2560, -1280, 4096, 2048, 16384, FILL_RANDOM);
    send_directed(2560, -1280, 4096, 2048, 32768, FILL_RANDOM);
    send_directed(2560, -1280, 4096, 2048, 49152, FILL_RANDOM);
    send_directed(-300, 700, 1000, 3000, 8191, FILL_RANDOM);
    send_directed(-300, 700, 1000, 3000, 8192, FILL_RANDOM);
    send_directed(-300, 700, 1000, 3000, 8193, FILL_RANDOM);
    send_directed(-300, 700, 1000, 3000, 57344, FILL_RANDOM);
    send_directed(-300, 700, 1000, 3000, 1, FILL_RANDOM);
    send_directed(-300, 700, 1000, 3000, 65535, FILL_RANDOM);
    send_directed(-5, 7, 1, 0, 16384, FILL_RANDOM);
    send_directed(3, -3, 3, 2, 16384, FILL_RANDOM);
    send_directed(-5, -5, 1, 1, 49152, FILL_RANDOM);
    send_directed(100, 100, 8388607, 1, 12000, FILL_RANDOM);
    send_directed(0, 0, 1, 8388607, 23000, FILL_RANDOM);
    send_directed(-1, -1, 8388607, 8388607, 0, FILL_ONES);
    drain();

    // random: sender gap rate 16%, then 87%, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 87 : 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 8));
        send_quad(random_quad());
      end
      drain();
    end

    // let any stray vertex show up before the verdict
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
